>>> rtl/core/scc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scc_pkg
// Shared types and constants of the strongly connected cycle finder.
// ----------------------------------------------------------------------------
package scc_pkg;

  localparam int NODE_W      = 5;
  localparam int NODE_SLOTS  = 32;
  localparam int MAX_NODES   = 32;
  localparam int NODE_LIMIT  = (MAX_NODES < NODE_SLOTS) ? MAX_NODES : NODE_SLOTS;
  localparam int DEPTH_W     = 6;
  localparam int GROUP_W     = 4;
  localparam int COUNT_W     = 5;
  localparam int EDGE_W      = 2 * NODE_W;
  localparam int MAX_EDGES_D = 256;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_RUN  = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [NODE_W-1:0] from_node;
    logic [NODE_W-1:0] to_node;
  } scc_in_t;

  typedef struct packed {
    logic [NODE_W-1:0]  member_node;
    logic [GROUP_W-1:0] group_index;
    logic               last_in_group;
    logic               finished;
    logic [COUNT_W-1:0] cycle_count;
    logic               edges_dropped;
  } scc_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROOT,
    ST_RREQ,
    ST_RCHK,
    ST_EREQ,
    ST_ECHK,
    ST_DONE,
    ST_CNT,
    ST_POP,
    ST_RET,
    ST_FIN
  } scc_state_t;

endpackage : scc_pkg
`default_nettype wire

>>> rtl/core/strongly_connected_cycle_finder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// strongly_connected_cycle_finder
// Finds the cycle groups (strongly connected components of more than one
// node) of a directed graph that is loaded one edge per request.
//
// A load request (mode 0) stores one edge, or drops it and sets the dropped-edge
// flag when a node is out of range or the store is full. A run request (mode 1)
// walks the graph depth first with an explicit frame stack and emits each cycle
// group member by member, then one closing result with the group count and the
// dropped-edge flag; the edge store is then empty again. In a run every visited
// node reads the whole store once, and each root candidate reads it until its
// first outgoing edge; each visited node then returns, and a group root also
// counts and pops its stack. The edge memory has a single read port.
// The input stall is high for the whole run. Results wait in an output
// register; a stalled receiver holds the walk only while a result is due.
// Reset empties the edge store and clears the main control state; the walk registers (pos, node, index) are not reset.
// ----------------------------------------------------------------------------
module strongly_connected_cycle_finder #(
  parameter int MAX_EDGES = scc_pkg::MAX_EDGES_D
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_stall,
  input  scc_pkg::scc_in_t in_data,
  output logic             out_valid,
  input  wire              out_stall,
  output scc_pkg::scc_out_t out_data
);
  import scc_pkg::*;

  localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EW = $clog2(MAX_EDGES + 1);

  logic [EDGE_W-1:0]  edge_mem [MAX_EDGES];
  logic [EDGE_W-1:0]  rdata_r;
  logic [NODE_W-1:0]  disc_mem [NODE_SLOTS];
  logic [NODE_W-1:0]  nstack   [NODE_SLOTS];
  logic [NODE_W-1:0]  fnode    [NODE_SLOTS];
  logic [EW-1:0]      fpos     [NODE_SLOTS];
  logic [NODE_W-1:0]  flow     [NODE_SLOTS];
  logic [NODE_W-1:0]  fdisc    [NODE_SLOTS];

  scc_state_t         state_r, state_nxt;
  logic [EW-1:0]      total_r, total_nxt;
  logic               ovf_r, ovf_nxt;
  logic [DEPTH_W-1:0] cnt_r, cnt_nxt;
  logic [DEPTH_W-1:0] sp_r, sp_nxt;
  logic [DEPTH_W-1:0] fp_r, fp_nxt;
  logic [COUNT_W-1:0] gc_r, gc_nxt;
  logic [DEPTH_W-1:0] root_r, root_nxt;
  logic [EW-1:0]      pos_r, pos_nxt;
  logic [NODE_W-1:0]  cur_v_r, cur_v_nxt;
  logic [NODE_W-1:0]  cur_low_r, cur_low_nxt;
  logic [NODE_W-1:0]  cur_disc_r, cur_disc_nxt;
  logic [DEPTH_W-1:0] idx_r, idx_nxt;
  logic               multi_r, multi_nxt;
  logic [NODE_SLOTS-1:0] visited_r, visited_nxt;
  logic [NODE_SLOTS-1:0] onstack_r, onstack_nxt;
  logic               out_valid_r;
  scc_out_t           out_data_r;

  logic               wr_en, rd_en, visit_en, save_en, emit;
  logic [AW-1:0]      rd_addr;
  logic [NODE_W-1:0]  visit_node;
  scc_out_t           emit_data;
  logic [NODE_W-1:0]  e_from, e_to, disc_w, top, ns_rd;
  logic [NODE_W-1:0]  p_idx, fp_top, sp_top;
  logic               can_emit;

  assign e_from   = rdata_r[EDGE_W-1:NODE_W];
  assign e_to     = rdata_r[NODE_W-1:0];
  assign disc_w   = disc_mem[e_to];
  assign p_idx    = NODE_W'(fp_r - DEPTH_W'(2));
  assign fp_top   = NODE_W'(fp_r - DEPTH_W'(1));
  assign sp_top   = NODE_W'(sp_r - DEPTH_W'(1));
  assign ns_rd    = nstack[(state_r == ST_CNT) ? idx_r[NODE_W-1:0] : sp_top];
  assign top      = ns_rd;
  assign can_emit = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt    = state_r;
    total_nxt    = total_r;
    ovf_nxt      = ovf_r;
    cnt_nxt      = cnt_r;
    sp_nxt       = sp_r;
    fp_nxt       = fp_r;
    gc_nxt       = gc_r;
    root_nxt     = root_r;
    pos_nxt      = pos_r;
    cur_v_nxt    = cur_v_r;
    cur_low_nxt  = cur_low_r;
    cur_disc_nxt = cur_disc_r;
    idx_nxt      = idx_r;
    multi_nxt    = multi_r;
    visited_nxt  = visited_r;
    onstack_nxt  = onstack_r;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = pos_r[AW-1:0];
    visit_en     = 1'b0;
    visit_node   = e_to;
    save_en      = 1'b0;
    emit         = 1'b0;
    emit_data    = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.mode == MODE_LOAD) begin
            if ({1'b0, in_data.from_node} >= (NODE_W+1)'(MAX_NODES) ||
                {1'b0, in_data.to_node} >= (NODE_W+1)'(MAX_NODES) ||
                total_r >= EW'(MAX_EDGES)) begin
              ovf_nxt = 1'b1;
            end else begin
              wr_en     = 1'b1;
              total_nxt = total_r + EW'(1);
            end
          end else begin
            visited_nxt = '0;
            onstack_nxt = '0;
            cnt_nxt     = '0;
            sp_nxt      = '0;
            fp_nxt      = '0;
            gc_nxt      = '0;
            root_nxt    = '0;
            state_nxt   = ST_ROOT;
          end
        end
      end
      ST_ROOT: begin
        if (root_r >= DEPTH_W'(NODE_LIMIT)) begin
          state_nxt = ST_FIN;
        end else if (visited_r[root_r[NODE_W-1:0]]) begin
          root_nxt = root_r + DEPTH_W'(1);
        end else begin
          pos_nxt   = '0;
          state_nxt = ST_RREQ;
        end
      end
      ST_RREQ: begin
        if (pos_r >= total_r) begin
          root_nxt  = root_r + DEPTH_W'(1);
          state_nxt = ST_ROOT;
        end else begin
          rd_en     = 1'b1;
          pos_nxt   = pos_r + EW'(1);
          state_nxt = ST_RCHK;
        end
      end
      ST_RCHK: begin
        if (e_from == root_r[NODE_W-1:0]) begin
          visit_en   = 1'b1;
          visit_node = root_r[NODE_W-1:0];
          state_nxt  = ST_EREQ;
        end else begin
          state_nxt = ST_RREQ;
        end
      end
      ST_EREQ: begin
        if (pos_r >= total_r) begin
          state_nxt = ST_DONE;
        end else begin
          rd_en     = 1'b1;
          pos_nxt   = pos_r + EW'(1);
          state_nxt = ST_ECHK;
        end
      end
      ST_ECHK: begin
        state_nxt = ST_EREQ;
        if (e_from == cur_v_r) begin
          if (!visited_r[e_to]) begin
            save_en  = 1'b1;
            visit_en = 1'b1;
          end else if (onstack_r[e_to] && disc_w < cur_low_r) begin
            cur_low_nxt = disc_w;
          end
        end
      end
      ST_DONE: begin
        if (cur_low_r == cur_disc_r) begin
          idx_nxt   = sp_r - DEPTH_W'(1);
          state_nxt = ST_CNT;
        end else begin
          state_nxt = ST_RET;
        end
      end
      ST_CNT: begin
        if (ns_rd == cur_v_r) begin
          multi_nxt = (idx_r != sp_r - DEPTH_W'(1));
          state_nxt = ST_POP;
        end else begin
          idx_nxt = idx_r - DEPTH_W'(1);
        end
      end
      ST_POP: begin
        if (!multi_r || can_emit) begin
          sp_nxt           = sp_r - DEPTH_W'(1);
          onstack_nxt[top] = 1'b0;
          if (multi_r) begin
            emit                    = 1'b1;
            emit_data.member_node   = top;
            emit_data.group_index   = gc_r[GROUP_W-1:0];
            emit_data.last_in_group = (top == cur_v_r);
          end
          if (top == cur_v_r) begin
            if (multi_r) begin
              gc_nxt = gc_r + COUNT_W'(1);
            end
            state_nxt = ST_RET;
          end
        end
      end
      ST_RET: begin
        fp_nxt = fp_r - DEPTH_W'(1);
        if (fp_r == DEPTH_W'(1)) begin
          root_nxt  = root_r + DEPTH_W'(1);
          state_nxt = ST_ROOT;
        end else begin
          cur_v_nxt    = fnode[p_idx];
          pos_nxt      = fpos[p_idx];
          cur_disc_nxt = fdisc[p_idx];
          cur_low_nxt  = (cur_low_r < flow[p_idx]) ? cur_low_r : flow[p_idx];
          state_nxt    = ST_EREQ;
        end
      end
      ST_FIN: begin
        if (can_emit) begin
          emit                    = 1'b1;
          emit_data.finished      = 1'b1;
          emit_data.cycle_count   = gc_r;
          emit_data.edges_dropped = ovf_r;
          total_nxt               = '0;
          ovf_nxt                 = 1'b0;
          state_nxt               = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (visit_en) begin
      visited_nxt[visit_node] = 1'b1;
      onstack_nxt[visit_node] = 1'b1;
      cnt_nxt      = cnt_r + DEPTH_W'(1);
      sp_nxt       = (sp_r < DEPTH_W'(NODE_SLOTS)) ? sp_r + DEPTH_W'(1) : sp_r;
      fp_nxt       = (fp_r < DEPTH_W'(NODE_SLOTS)) ? fp_r + DEPTH_W'(1) : fp_r;
      cur_v_nxt    = visit_node;
      cur_low_nxt  = cnt_r[NODE_W-1:0];
      cur_disc_nxt = cnt_r[NODE_W-1:0];
      pos_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      edge_mem[total_r[AW-1:0]] <= {in_data.from_node, in_data.to_node};
    end
    if (rd_en) begin
      rdata_r <= edge_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (visit_en) begin
      disc_mem[visit_node] <= cnt_r[NODE_W-1:0];
      if (sp_r < DEPTH_W'(NODE_SLOTS)) begin
        nstack[sp_r[NODE_W-1:0]] <= visit_node;
      end
      if (fp_r < DEPTH_W'(NODE_SLOTS)) begin
        fnode[fp_r[NODE_W-1:0]] <= visit_node;
        fdisc[fp_r[NODE_W-1:0]] <= cnt_r[NODE_W-1:0];
      end
    end
    if (save_en) begin
      fpos[fp_top] <= pos_r;
      flow[fp_top] <= cur_low_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      total_r     <= '0;
      ovf_r       <= 1'b0;
      cnt_r       <= '0;
      sp_r        <= '0;
      fp_r        <= '0;
      gc_r        <= '0;
      root_r      <= '0;
      visited_r   <= '0;
      onstack_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      total_r   <= total_nxt;
      ovf_r     <= ovf_nxt;
      cnt_r     <= cnt_nxt;
      sp_r      <= sp_nxt;
      fp_r      <= fp_nxt;
      gc_r      <= gc_nxt;
      root_r    <= root_nxt;
      visited_r <= visited_nxt;
      onstack_r <= onstack_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    cur_v_r    <= cur_v_nxt;
    cur_low_r  <= cur_low_nxt;
    cur_disc_r <= cur_disc_nxt;
    idx_r      <= idx_nxt;
    multi_r    <= multi_nxt;
    if (emit) begin
      out_data_r <= emit_data;
    end
  end

endmodule : strongly_connected_cycle_finder
`default_nettype wire
